// ===== rtl/pur_pkg.sv =====
// ----------------------------------------------------------------------------
// pur_pkg
// Shared types and constants of the picture unit register port.
// ----------------------------------------------------------------------------
package pur_pkg;

  localparam int PATTERN_BYTES    = 8192;
  localparam int NAME_TABLE_BYTES = 2048;
  localparam int SPRITE_BYTES     = 256;

  localparam int PAT_AW = $clog2(PATTERN_BYTES);
  localparam int NT_AW  = $clog2(NAME_TABLE_BYTES);
  localparam int SPR_AW = $clog2(SPRITE_BYTES);

  // access commands
  localparam logic [2:0] CMD_REG_READ    = 3'd0;
  localparam logic [2:0] CMD_REG_WRITE   = 3'd1;
  localparam logic [2:0] CMD_SET_VBLANK  = 3'd2;
  localparam logic [2:0] CMD_CLR_VBLANK  = 3'd3;
  localparam logic [2:0] CMD_LOAD_PATTERN = 3'd4;

  // register indexes
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAMADR = 3'd3;
  localparam logic [2:0] REG_OAMDAT = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // configuration register indexes
  localparam logic CFG_VERT_MIRROR = 1'b0;
  localparam logic CFG_PAT_WRITE   = 1'b1;

  localparam logic [13:0] PALETTE_BASE = 14'h3F00;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              exec;
    logic              clear;
    logic [PAT_AW-1:0] clear_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/pur_controller.sv =====
// ----------------------------------------------------------------------------
// pur_controller
// Sequencer: memory clearing sweep after reset, then accept / execute.
// ----------------------------------------------------------------------------
module pur_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pur_pkg::dp_status_t status,
  output pur_pkg::dp_cmd_t    cmd
);
  import pur_pkg::*;

  state_t            state_r, state_nxt;
  logic [PAT_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd.accept     = 1'b0;
    cmd.exec       = 1'b0;
    cmd.clear      = 1'b0;
    cmd.clear_addr = clr_cnt_r;
    in_stall       = 1'b1;
    case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EXEC: cmd.exec = status.out_free;
      default: in_stall = 1'b1;
    endcase
  end

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_EXEC) else $error("accept not followed by exec");
  a_exec_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> status.out_free) else $error("exec with output busy");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !cmd.accept && !cmd.exec) else $error("work during clear");

endmodule

// ===== rtl/pur_datapath.sv =====
// ----------------------------------------------------------------------------
// pur_datapath
// Register file, scroll latches, stores and the output register.
// ----------------------------------------------------------------------------
module pur_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  pur_pkg::dp_cmd_t    cmd,
  output pur_pkg::dp_status_t status,
  input  logic [2:0]          in_command,
  input  logic [2:0]          in_reg_index,
  input  logic [7:0]          in_data_in,
  input  logic [12:0]         in_load_address,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic                cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_read_data,
  output logic                out_nmi_request
);
  import pur_pkg::*;

  // captured access
  logic [2:0]  cmd_r, reg_r;
  logic [7:0]  data_r;
  logic [12:0] ld_addr_r;

  logic vmirror_r, pat_wr_r;

  logic [7:0]  ctrl_r, ctrl_nxt, mask_r, mask_nxt, status_r, status_nxt;
  logic [7:0]  spr_addr_r, spr_addr_nxt, rbuf_r, rbuf_nxt;
  logic [14:0] taddr_r, taddr_nxt, vaddr_r, vaddr_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic        toggle_r, toggle_nxt, vbo_r, vbo_nxt, nmi_r, nmi_nxt;
  logic        out_valid_r;
  logic [7:0]  out_data_r, result;

  logic [7:0] spr_mem [SPRITE_BYTES];
  logic [7:0] pat_mem [PATTERN_BYTES];
  logic [7:0] nt_mem  [NAME_TABLE_BYTES];
  logic [7:0] pal_r   [16];

  logic [7:0] spr_rd_r, pat_rd_r, nt_rd_r;

  logic [13:0]       va;
  logic              in_pat, in_pal;
  logic [NT_AW-1:0]  nt_idx;
  logic [7:0]        mem_rd;

  logic              spr_we, pat_we, nt_we, pal_we;
  logic [SPR_AW-1:0] spr_wa;
  logic [PAT_AW-1:0] pat_wa;
  logic [NT_AW-1:0]  nt_wa;
  logic [7:0]        spr_wd, pat_wd, nt_wd, pal_wd;
  logic [3:0]        pal_wa;

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_nmi_request = nmi_r;

  assign va     = vaddr_r[13:0];
  assign in_pat = !va[13];
  assign in_pal = va >= PALETTE_BASE;
  assign nt_idx = {(vmirror_r ? va[10] : va[11]), va[9:0]};
  assign mem_rd = in_pat ? pat_rd_r : (in_pal ? pal_r[va[3:0]] : nt_rd_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r     <= in_command;
      reg_r     <= in_reg_index;
      data_r    <= in_data_in;
      ld_addr_r <= in_load_address;
    end
    if (cmd.exec) out_data_r <= result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmirror_r <= 1'b0;
      pat_wr_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VERT_MIRROR: vmirror_r <= cfg_data;
        CFG_PAT_WRITE:   pat_wr_r  <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_comb begin
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    spr_addr_nxt = spr_addr_r;
    rbuf_nxt     = rbuf_r;
    taddr_nxt    = taddr_r;
    vaddr_nxt    = vaddr_r;
    fine_x_nxt   = fine_x_r;
    toggle_nxt   = toggle_r;
    vbo_nxt      = vbo_r;
    nmi_nxt      = nmi_r;
    result       = '0;
    spr_we = 1'b0; spr_wa = spr_addr_r; spr_wd = data_r;
    pat_we = 1'b0; pat_wa = va[PAT_AW-1:0]; pat_wd = data_r;
    nt_we  = 1'b0; nt_wa  = nt_idx; nt_wd = data_r;
    pal_we = 1'b0; pal_wa = va[3:0]; pal_wd = data_r;
    case (cmd_r)
      CMD_REG_READ: begin
        case (reg_r)
          REG_STATUS: begin
            result     = status_r;
            status_nxt = {1'b0, status_r[6:0]};
            vbo_nxt    = 1'b0;
            toggle_nxt = 1'b0;
          end
          REG_OAMDAT: result = spr_rd_r;
          REG_DATA: begin
            if (in_pal) begin
              result = mem_rd;
            end else begin
              result   = rbuf_r;
              rbuf_nxt = mem_rd;
            end
            vaddr_nxt = vaddr_r + (ctrl_r[2] ? 15'd32 : 15'd1);
          end
          default: result = '0;
        endcase
      end
      CMD_REG_WRITE: begin
        case (reg_r)
          REG_CTRL: begin
            ctrl_nxt  = data_r;
            taddr_nxt = {taddr_r[14:12], data_r[1:0], taddr_r[9:0]};
            if (!ctrl_r[7] && data_r[7] && vbo_r) nmi_nxt = 1'b1;
          end
          REG_MASK:   mask_nxt = data_r;
          REG_OAMADR: spr_addr_nxt = data_r;
          REG_OAMDAT: begin
            spr_we       = 1'b1;
            spr_addr_nxt = spr_addr_r + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle_r) begin
              taddr_nxt  = {taddr_r[14:5], data_r[7:3]};
              fine_x_nxt = data_r[2:0];
            end else begin
              taddr_nxt = {data_r[2:0], taddr_r[11:10], data_r[7:3], taddr_r[4:0]};
            end
            toggle_nxt = !toggle_r;
          end
          REG_ADDR: begin
            if (!toggle_r) begin
              taddr_nxt = {1'b0, data_r[5:0], taddr_r[7:0]};
            end else begin
              taddr_nxt = {taddr_r[14:8], data_r};
              vaddr_nxt = {taddr_r[14:8], data_r};
            end
            toggle_nxt = !toggle_r;
          end
          REG_DATA: begin
            if (in_pat)      pat_we = pat_wr_r;
            else if (in_pal) pal_we = 1'b1;
            else             nt_we  = 1'b1;
            vaddr_nxt = vaddr_r + (ctrl_r[2] ? 15'd32 : 15'd1);
          end
          default: ;
        endcase
      end
      CMD_SET_VBLANK: begin
        status_nxt = {1'b1, status_r[6:0]};
        vbo_nxt    = 1'b1;
        if (ctrl_r[7]) nmi_nxt = 1'b1;
      end
      CMD_CLR_VBLANK: begin
        status_nxt = {1'b0, status_r[6:0]};
        vbo_nxt    = 1'b0;
        nmi_nxt    = 1'b0;
      end
      CMD_LOAD_PATTERN: begin
        pat_we = 1'b1;
        pat_wa = ld_addr_r;
      end
      default: ;
    endcase
    if (!cmd.exec) begin
      spr_we = 1'b0;
      pat_we = 1'b0;
      nt_we  = 1'b0;
      pal_we = 1'b0;
    end
    if (cmd.clear) begin
      spr_we = 1'b1; spr_wa = cmd.clear_addr[SPR_AW-1:0]; spr_wd = '0;
      pat_we = 1'b1; pat_wa = cmd.clear_addr;             pat_wd = '0;
      nt_we  = 1'b1; nt_wa  = cmd.clear_addr[NT_AW-1:0];  nt_wd  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      mask_r      <= '0;
      status_r    <= '0;
      spr_addr_r  <= '0;
      rbuf_r      <= '0;
      taddr_r     <= '0;
      vaddr_r     <= '0;
      fine_x_r    <= '0;
      toggle_r    <= 1'b0;
      vbo_r       <= 1'b0;
      nmi_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        ctrl_r     <= ctrl_nxt;
        mask_r     <= mask_nxt;
        status_r   <= status_nxt;
        spr_addr_r <= spr_addr_nxt;
        rbuf_r     <= rbuf_nxt;
        taddr_r    <= taddr_nxt;
        vaddr_r    <= vaddr_nxt;
        fine_x_r   <= fine_x_nxt;
        toggle_r   <= toggle_nxt;
        vbo_r      <= vbo_nxt;
        nmi_r      <= nmi_nxt;
      end
      if (cmd.exec)          out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  // palette lives in flops so reset clears it at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) pal_r[i] <= '0;
    end else if (pal_we) begin
      pal_r[pal_wa] <= pal_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (spr_we) spr_mem[spr_wa] <= spr_wd;
    spr_rd_r <= spr_mem[spr_addr_r];
  end

  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pat_wa] <= pat_wd;
    pat_rd_r <= pat_mem[va[PAT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nt_we) nt_mem[nt_wa] <= nt_wd;
    nt_rd_r <= nt_mem[nt_idx];
  end

endmodule

// ===== rtl/picture_unit_register_port_unit.sv =====
// ----------------------------------------------------------------------------
// picture_unit_register_port_unit
// Register port of a tile picture unit with scroll latches and local stores.
// ----------------------------------------------------------------------------
// An accepted beat is captured, then executed once the result register is free,
//   which loads the result register. No new access is taken before execute; the
//   stores' registered read ports are why execute follows accept in its own state.
// Reset: rst_n synchronous; then a clearing sweep of all 8192 pattern addresses
//   zeroes pattern, name table and sprite stores, in_stall held high meanwhile.
// Configuration writes are taken at any time (cfg_ready is always high).
module picture_unit_register_port_unit (
  input  logic        clk,
  input  logic        rst_n,
  // access channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [2:0]  in_reg_index,
  input  logic [7:0]  in_data_in,
  input  logic [12:0] in_load_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_nmi_request,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import pur_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  // sequence the sweep, then accept and execute one beat at a time
  pur_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // hold all architectural state and drive the result register
  pur_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_command      (in_command),
    .in_reg_index    (in_reg_index),
    .in_data_in      (in_data_in),
    .in_load_address (in_load_address),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_nmi_request (out_nmi_request)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the picture unit register port: a directed table of
// accesses followed by random register traffic, all scored against a local
// model of the registers, scroll latches, read buffer and stores.
// ----------------------------------------------------------------------------
module tb;
  import pur_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = '0;
  logic [2:0]  in_reg_index = '0;
  logic [7:0]  in_data_in = '0;
  logic [12:0] in_load_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_nmi_request;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic        cfg_data = 1'b0;

  picture_unit_register_port_unit DUT (.*);

  always #4 clk = ~clk;

  // one access and the beat it should produce
  typedef struct {
    logic [2:0]  cmd;
    logic [2:0]  rix;
    logic [7:0]  data;
    logic [12:0] addr;
  } access_t;

  typedef struct {
    logic [7:0] rd;
    logic       nmi;
  } reply_t;

  // ---- shadow of the block's state ----
  logic       m_vmirror, m_patwr;
  logic [7:0] m_ctrl, m_mask, m_status, m_oam_addr, m_rdbuf;
  logic [7:0] m_oam [SPRITE_BYTES];
  logic [14:0] m_t, m_v;
  logic [2:0] m_fine_x;
  logic       m_toggle, m_vbl, m_nmi;
  logic [7:0] m_pat [PATTERN_BYTES];
  logic [7:0] m_nt [NAME_TABLE_BYTES];
  logic [7:0] m_pal [16];

  reply_t replies_due [$];
  int     errors = 0;
  int     cycles = 0;
  bit     quiet = 1'b0;   // no idling in the closing stretch

  function automatic logic [10:0] nt_slot(logic [13:0] a);
    logic [1:0] tbl;
    logic bank;
    tbl = a[11:10];
    bank = m_vmirror ? tbl[0] : tbl[1];
    return {bank, a[9:0]};
  endfunction

  function automatic logic [7:0] vram_peek(logic [13:0] a);
    if (a < 14'h2000) return m_pat[a[12:0]];
    if (a < PALETTE_BASE) return m_nt[nt_slot(a)];
    return m_pal[a[3:0]];
  endfunction

  function automatic void vram_poke(logic [13:0] a, logic [7:0] d);
    if (a < 14'h2000) begin
      if (m_patwr) m_pat[a[12:0]] = d;
    end else if (a < PALETTE_BASE) begin
      m_nt[nt_slot(a)] = d;
    end else begin
      m_pal[a[3:0]] = d;
    end
  endfunction

  function automatic void bump_vram();
    m_v = m_v + (m_ctrl[2] ? 15'd32 : 15'd1);
  endfunction

  function automatic void clear_shadow();
    m_vmirror = 0; m_patwr = 1;
    m_ctrl = 0; m_mask = 0; m_status = 0; m_oam_addr = 0; m_rdbuf = 0;
    m_t = 0; m_v = 0; m_fine_x = 0; m_toggle = 0; m_vbl = 0; m_nmi = 0;
    foreach (m_oam[i]) m_oam[i] = 0;
    foreach (m_pat[i]) m_pat[i] = 0;
    foreach (m_nt[i]) m_nt[i] = 0;
    foreach (m_pal[i]) m_pal[i] = 0;
  endfunction

  // advance the shadow by one access and return the beat it yields
  function automatic reply_t port_access(access_t a);
    reply_t r;
    logic [7:0] v;
    r.rd = 0;
    case (a.cmd)
      CMD_REG_READ: begin
        case (a.rix)
          REG_STATUS: begin
            r.rd = m_status;
            m_status[7] = 0; m_vbl = 0; m_toggle = 0;
          end
          REG_OAMDAT: r.rd = m_oam[m_oam_addr];
          REG_DATA: begin
            v = vram_peek(m_v[13:0]);
            if (m_v[13:0] < PALETTE_BASE) begin
              r.rd = m_rdbuf; m_rdbuf = v;
            end else begin
              r.rd = v;
            end
            bump_vram();
          end
          default: ;
        endcase
      end
      CMD_REG_WRITE: begin
        case (a.rix)
          REG_CTRL: begin
            if (!m_ctrl[7] && a.data[7] && m_vbl) m_nmi = 1;
            m_ctrl = a.data;
            m_t[11:10] = a.data[1:0];
          end
          REG_MASK: m_mask = a.data;
          REG_OAMADR: m_oam_addr = a.data;
          REG_OAMDAT: begin
            m_oam[m_oam_addr] = a.data;
            m_oam_addr++;
          end
          REG_SCROLL: begin
            if (!m_toggle) begin
              m_t[4:0] = a.data[7:3]; m_fine_x = a.data[2:0];
            end else begin
              m_t[9:5] = a.data[7:3]; m_t[14:12] = a.data[2:0];
            end
            m_toggle = !m_toggle;
          end
          REG_ADDR: begin
            if (!m_toggle) begin
              m_t[13:8] = a.data[5:0]; m_t[14] = 0;
            end else begin
              m_t[7:0] = a.data; m_v = m_t;
            end
            m_toggle = !m_toggle;
          end
          REG_DATA: begin
            vram_poke(m_v[13:0], a.data);
            bump_vram();
          end
          default: ;
        endcase
      end
      CMD_SET_VBLANK: begin
        m_status[7] = 1; m_vbl = 1;
        if (m_ctrl[7]) m_nmi = 1;
      end
      CMD_CLR_VBLANK: begin
        m_status[7] = 0; m_vbl = 0; m_nmi = 0;
      end
      CMD_LOAD_PATTERN: m_pat[a.addr] = a.data;
      default: ;
    endcase
    r.nmi = m_nmi;
    return r;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  // present one beat, hold it until taken, then score it up front
  task automatic send_access(access_t a);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      idle_burst();
    end
    in_valid <= 1'b1;
    in_command <= a.cmd;
    in_reg_index <= a.rix;
    in_data_in <= a.data;
    in_load_address <= a.addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replies_due.push_back(port_access(a));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // one write, then cfg_valid is dropped so back-to-back writes never collide
  task automatic write_cfg(logic idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_VERT_MIRROR) m_vmirror = val;
    else m_patwr = val;
    @(posedge clk);
  endtask

  // result side: stall in bursts, compare each beat against the oldest reply
  always @(posedge clk) begin
    reply_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat rd=%h nmi=%b", out_read_data,
                                   out_nmi_request);
      end else begin
        e = replies_due.pop_front();
        if (out_read_data !== e.rd || out_nmi_request !== e.nmi) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected rd=%h nmi=%b, got rd=%h nmi=%b",
                     e.rd, e.nmi, out_read_data, out_nmi_request);
        end
      end
    end
  end

  initial begin : stall_gen
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        idle_burst();
      end
    end
  end

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // directed table; fixed expectations only where obvious, other rows predicted by the shadow
  typedef struct {
    access_t a;
    bit      fixed;
    reply_t  r;
  } row_t;

  row_t plan [$];

  function automatic void row(logic [2:0] c, logic [2:0] ri, logic [7:0] d,
                              logic [12:0] ad, bit fx = 0, logic [7:0] rd = 0,
                              logic nmi = 0);
    row_t w;
    w.a = '{c, ri, d, ad};
    w.fixed = fx;
    w.r = '{rd, nmi};
    plan.push_back(w);
  endfunction

  function automatic access_t rand_access();
    access_t a;
    int p;
    a.cmd = CMD_REG_WRITE;
    a.rix = 3'($urandom_range(0, 7));
    a.data = 8'($urandom_range(0, 255));
    a.addr = 13'($urandom_range(0, 8191));
    p = $urandom_range(0, 99);
    if (p < 35) a.cmd = CMD_REG_READ;
    else if (p < 80) a.cmd = CMD_REG_WRITE;
    else if (p < 86) a.cmd = CMD_SET_VBLANK;
    else if (p < 91) a.cmd = CMD_CLR_VBLANK;
    else if (p < 97) a.cmd = CMD_LOAD_PATTERN;
    else a.cmd = 3'($urandom_range(5, 7));
    // favor the data port so the stores see traffic
    if (a.cmd inside {CMD_REG_READ, CMD_REG_WRITE} && $urandom_range(0, 1))
      a.rix = REG_DATA;
    return a;
  endfunction

  initial begin : stimulus
    reply_t got;
    logic [7:0] hi;
    clear_shadow();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // after reset, extremes, every command and register, special cases
    row(CMD_REG_READ, REG_STATUS, 8'h00, 0, 1, 8'h00, 0);
    row(CMD_REG_READ, REG_CTRL, 8'hFF, 13'h1FFF, 1, 8'h00, 0);
    row(CMD_REG_WRITE, REG_STATUS, 8'hFF, 0, 1, 8'h00, 0);
    row(CMD_SET_VBLANK, 0, 0, 0, 1, 8'h00, 0);
    row(CMD_REG_WRITE, REG_CTRL, 8'h80, 0, 1, 8'h00, 1);   // late enable fires
    row(CMD_REG_READ, REG_STATUS, 0, 0, 1, 8'h80, 1);
    row(CMD_REG_READ, REG_STATUS, 0, 0, 1, 8'h00, 1);      // nmi stays latched
    row(CMD_CLR_VBLANK, 0, 0, 0, 1, 8'h00, 0);
    row(CMD_LOAD_PATTERN, 0, 8'hFF, 13'h1FFF);
    row(CMD_REG_WRITE, REG_ADDR, 8'hFF, 0);
    row(CMD_REG_WRITE, REG_ADDR, 8'hFF, 0);
    row(CMD_REG_READ, REG_DATA, 0, 0);                      // unbuffered palette read
    row(CMD_REG_WRITE, REG_DATA, 8'h5A, 0);                 // wraps to pattern address 0
    row(CMD_REG_WRITE, REG_ADDR, 8'h3F, 0);
    row(CMD_REG_WRITE, REG_ADDR, 8'h0F, 0);
    row(CMD_REG_READ, REG_DATA, 0, 0);                      // unbuffered
    row(CMD_REG_WRITE, REG_OAMADR, 8'hFF, 0);
    row(CMD_REG_WRITE, REG_OAMDAT, 8'hA5, 0);
    row(CMD_REG_WRITE, REG_SCROLL, 8'hFF, 0);
    row(CMD_REG_WRITE, REG_SCROLL, 8'h00, 0);
    row(CMD_REG_WRITE, REG_MASK, 8'hFF, 0);
    row(CMD_REG_READ, REG_OAMDAT, 0, 0);
    row(3'd7, REG_DATA, 8'hFF, 13'h1FFF, 1, 8'h00, 0);
    row(CMD_REG_WRITE, REG_CTRL, 8'h04, 0);                 // step by 32

    foreach (plan[i]) begin
      send_access(plan[i].a);
      if (plan[i].fixed) begin
        got = replies_due[$];
        if (got.rd !== plan[i].r.rd || got.nmi !== plan[i].r.nmi) begin
          errors++;
          if (errors <= 10)
            $display("table row %0d: expected rd=%h nmi=%b, got rd=%h nmi=%b", i,
                     plan[i].r.rd, plan[i].r.nmi, got.rd, got.nmi);
        end
      end
    end
    drain();

    // phases over the configuration corners, pattern locked in two of them
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(CFG_VERT_MIRROR, ph[0]);
      write_cfg(CFG_PAT_WRITE, (ph == 1 || ph == 4) ? 1'b0 : 1'b1);
      quiet = (ph == 4);
      for (int n = 0; n < 400; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          // well-formed address pair, aimed at any of the three regions
          hi = 8'($urandom_range(0, 255));
          send_access('{CMD_REG_READ, REG_STATUS, 8'h00, 13'h0});
          send_access('{CMD_REG_WRITE, REG_ADDR, hi, 13'h0});
          send_access('{CMD_REG_WRITE, REG_ADDR, 8'($urandom_range(0, 255)), 13'h0});
        end else begin
          send_access(rand_access());
        end
      end
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
